/* hdl/integer_vector_alu_defines.svh */
// Assertion macros shared by the integer vector ALU RTL.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef INTEGER_VECTOR_ALU_DEFINES_SVH
`define INTEGER_VECTOR_ALU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IVALU_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define IVALU_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hdl/ivalu_pkg.sv */
// Package for the integer vector ALU: widths, opcodes, status codes and
// the request, result and pipeline context types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ivalu_pkg;

	localparam int CompW     = 32;
	localparam int Lanes     = 4;
	localparam int SqrtSteps = CompW / 2;
	localparam int DivSteps  = CompW;

	typedef logic signed [CompW-1:0] comp_t;

	// Opcodes
	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_SCALE = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_DOT   = 4'd4;
	localparam logic [3:0] OP_CROSS = 4'd5;
	localparam logic [3:0] OP_MAG   = 4'd6;
	localparam logic [3:0] OP_NORM  = 4'd7;
	localparam logic [3:0] OP_QSUM  = 4'd8;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DIV0   = 2'd1;
	localparam logic [1:0] ST_CROSS4 = 2'd2;

	typedef struct packed {
		logic        [3:0]  opcode;
		logic        [2:0]  dims;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
		logic signed [31:0] factor;
	} req_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_w;
		logic signed [31:0] r_scalar;
		logic        [1:0]  status;
	} rsp_t;

	// Operands for one lane
	typedef struct packed {
		logic [3:0] op;
		comp_t      a;
		comp_t      b;
		comp_t      f;
		comp_t      ca;
		comp_t      cb;
		comp_t      cc;
		comp_t      cd;
	} lane_in_t;

	// First-stage lane results
	typedef struct packed {
		comp_t vec;
		comp_t ab;
		comp_t aa;
	} lane_s1_t;

	// Item context carried down the pipeline
	typedef struct packed {
		logic [3:0]             op;
		logic [2:0]             n;
		comp_t [Lanes-1:0]      a;
		comp_t [Lanes-1:0]      b;
		comp_t                  f;
		comp_t [Lanes-1:0]      vec;
		comp_t                  sc;
		logic [1:0]             st;
	} ctx_t;

endpackage

`default_nettype wire

/* hdl/ivalu_lane.sv */
// One component lane: add/sub/scale, the a*b and a*a products, and one
// cross-product term. Depends on ivalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ivalu_lane (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire ivalu_pkg::lane_in_t lin,
	output ivalu_pkg::lane_s1_t      res_s1,
	output ivalu_pkg::comp_t         cross_s2
);

	ivalu_pkg::comp_t vec_d;
	ivalu_pkg::comp_t cp_s1;
	ivalu_pkg::comp_t cq_s1;

	// Element-wise result
	always_comb begin
		case (lin.op)
			ivalu_pkg::OP_ADD:   vec_d = lin.a + lin.b;
			ivalu_pkg::OP_SUB:   vec_d = lin.a - lin.b;
			ivalu_pkg::OP_SCALE: vec_d = lin.a * lin.f;
			default:             vec_d = '0;
		endcase
	end

	// Stage 1: products, wrapped to the component width
	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.vec <= vec_d;
			res_s1.ab  <= lin.a * lin.b;
			res_s1.aa  <= lin.a * lin.a;
			cp_s1      <= lin.ca * lin.cb;
			cq_s1      <= lin.cc * lin.cd;
		end
	end

	// Stage 2: cross term difference
	always_ff @(posedge clk) begin
		if (en) begin
			cross_s2 <= cp_s1 - cq_s1;
		end
	end

endmodule

`default_nettype wire

/* hdl/ivalu_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Depends on ivalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ivalu_sqrt (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [ivalu_pkg::CompW-1:0] value,
	output ivalu_pkg::comp_t            root
);

	localparam int W = ivalu_pkg::CompW;
	localparam int N = ivalu_pkg::SqrtSteps;

	logic [W-1:0] rem_s  [N];
	logic [W-1:0] root_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W-1:0] Bit = {{(W-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
		logic [W-1:0] v_in;
		logic [W-1:0] r_in;
		logic [W-1:0] trial;
		logic [W-1:0] v_nx;
		logic [W-1:0] r_nx;

		// One digit of the restoring square root
		always_comb begin
			v_in  = (k == 0) ? value : rem_s[(k == 0) ? 0 : k - 1];
			r_in  = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k - 1];
			trial = r_in + Bit;
			if (v_in >= trial) begin
				v_nx = v_in - trial;
				r_nx = (r_in >> 1) + Bit;
			end else begin
				v_nx = v_in;
				r_nx = r_in >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= v_nx;
				root_s[k] <= r_nx;
			end
		end
	end

	assign root = ivalu_pkg::comp_t'(root_s[N-1]);

endmodule

`default_nettype wire

/* hdl/ivalu_div.sv */
// Pipelined signed divider truncating toward zero: one quotient bit per
// stage plus a sign fix stage. Depends on ivalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ivalu_div (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire ivalu_pkg::comp_t dividend,
	input  wire ivalu_pkg::comp_t divisor,
	output ivalu_pkg::comp_t      quot
);

	localparam int W = ivalu_pkg::CompW;
	localparam int N = ivalu_pkg::DivSteps;

	logic [W:0]   rem_s [N];
	logic [W-1:0] quo_s [N];
	logic [W-1:0] dvs_s [N];
	logic         neg_s [N];
	logic [W-1:0] abs_n;
	logic [W-1:0] abs_d;

	// Operand magnitudes; the most negative value maps to its unsigned magnitude
	assign abs_n = dividend[W-1] ? W'(-dividend) : W'(dividend);
	assign abs_d = divisor[W-1]  ? W'(-divisor)  : W'(divisor);

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W:0]   r_in;
		logic [W-1:0] q_in;
		logic [W-1:0] d_in;
		logic         n_in;
		logic [W:0]   sh;
		logic [W:0]   r_nx;
		logic [W-1:0] q_nx;

		// Shift in one dividend bit, subtract if it fits
		always_comb begin
			r_in = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k - 1];
			q_in = (k == 0) ? abs_n : quo_s[(k == 0) ? 0 : k - 1];
			d_in = (k == 0) ? abs_d : dvs_s[(k == 0) ? 0 : k - 1];
			n_in = (k == 0) ? (dividend[W-1] ^ divisor[W-1]) : neg_s[(k == 0) ? 0 : k - 1];
			sh   = {r_in[W-1:0], q_in[W-1]};
			q_nx = {q_in[W-2:0], 1'b0};
			if (sh >= {1'b0, d_in}) begin
				r_nx    = sh - {1'b0, d_in};
				q_nx[0] = 1'b1;
			end else begin
				r_nx = sh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				quo_s[k] <= q_nx;
				dvs_s[k] <= d_in;
				neg_s[k] <= n_in;
			end
		end
	end

	// Sign fix
	always_ff @(posedge clk) begin
		if (en) begin
			quot <= neg_s[N-1] ? ivalu_pkg::comp_t'(-quo_s[N-1])
			                   : ivalu_pkg::comp_t'(quo_s[N-1]);
		end
	end

endmodule

`default_nettype wire

/* hdl/integer_vector_alu.sv */
// Integer vector ALU top level: four component lanes, square root and
// divider pipelines, merge stage. Depends on ivalu_pkg, ivalu_lane,
// ivalu_sqrt, ivalu_div and integer_vector_alu_defines.svh.
//
// Usage:
//   Requests enter on req/req_valid and are taken at a clock edge where
//   req_valid is high and req_stall is low. Results leave on rsp/rsp_valid
//   and are taken when rsp_valid is high and rsp_stall is low.
//   Every request gives exactly one result, in order.
//   The path from acceptance to the result register has 2 lane stages,
//   16 square root stages, 33 divider stages and 1 output stage.
//   All opcodes take the same path so that order is kept.
//   Throughput: one request per cycle while req_stall is low; the pipeline
//   holds up to 52 items. When the receiver stalls a waiting result, the
//   whole pipeline freezes and req_stall rises in the same cycle; it falls
//   as soon as the result is taken.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_vector_alu_defines.svh"

module integer_vector_alu (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire ivalu_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output ivalu_pkg::rsp_t      rsp
);

	localparam int W  = ivalu_pkg::CompW;
	localparam int L  = ivalu_pkg::Lanes;
	localparam int SQ = ivalu_pkg::SqrtSteps;
	localparam int DV = ivalu_pkg::DivSteps + 1;

	logic en;

	ivalu_pkg::comp_t [L-1:0] a_in;
	ivalu_pkg::comp_t [L-1:0] b_in;
	ivalu_pkg::comp_t         f_in;
	logic [2:0]               n_in;
	ivalu_pkg::ctx_t          ctx_d;

	ivalu_pkg::lane_s1_t      lane_s1  [L];
	ivalu_pkg::comp_t         cross_s2 [L];

	ivalu_pkg::ctx_t ctx_s1;
	ivalu_pkg::ctx_t ctx_s2;
	logic            v_s1;
	logic            v_s2;
	ivalu_pkg::comp_t sqsum_s2;

	ivalu_pkg::ctx_t ctx_sq [SQ];
	logic            v_sq   [SQ];
	ivalu_pkg::ctx_t sq_in;
	logic [W-1:0]    sqrt_val;
	ivalu_pkg::comp_t mag;

	ivalu_pkg::ctx_t ctx_dv [DV];
	logic            v_dv   [DV];
	ivalu_pkg::ctx_t dv_in;
	ivalu_pkg::comp_t dvsr  [L];
	ivalu_pkg::comp_t quot  [L];

	ivalu_pkg::ctx_t fin;
	logic            rsp_valid_q;
	ivalu_pkg::rsp_t rsp_q;
	logic            rsp_zero;

	// Pipeline advances unless a finished result is held
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	// Request unpacking and early status
	always_comb begin
		a_in = {ivalu_pkg::comp_t'(req.a_w[W-1:0]), ivalu_pkg::comp_t'(req.a_z[W-1:0]),
		        ivalu_pkg::comp_t'(req.a_y[W-1:0]), ivalu_pkg::comp_t'(req.a_x[W-1:0])};
		b_in = {ivalu_pkg::comp_t'(req.b_w[W-1:0]), ivalu_pkg::comp_t'(req.b_z[W-1:0]),
		        ivalu_pkg::comp_t'(req.b_y[W-1:0]), ivalu_pkg::comp_t'(req.b_x[W-1:0])};
		f_in = ivalu_pkg::comp_t'(req.factor[W-1:0]);
		n_in = (req.dims < 3'd2) ? 3'd2 : ((req.dims > 3'd4) ? 3'd4 : req.dims);
		ctx_d     = '0;
		ctx_d.op  = req.opcode;
		ctx_d.n   = n_in;
		ctx_d.a   = a_in;
		ctx_d.b   = b_in;
		ctx_d.f   = f_in;
		ctx_d.st  = ivalu_pkg::ST_OK;
		case (req.opcode)
			ivalu_pkg::OP_DIV: begin
				if (f_in == '0) ctx_d.st = ivalu_pkg::ST_DIV0;
			end
			ivalu_pkg::OP_CROSS: begin
				if (n_in == 3'd4) ctx_d.st = ivalu_pkg::ST_CROSS4;
			end
			ivalu_pkg::OP_QSUM: begin
				for (int i = 0; i < L; i++) begin
					if (3'(i) < n_in && b_in[i] == '0) ctx_d.st = ivalu_pkg::ST_DIV0;
				end
			end
			default: ;
		endcase
	end

	// Component lanes
	for (genvar i = 0; i < L; i++) begin : g_lane
		ivalu_pkg::lane_in_t lin;
		always_comb begin
			lin.op = req.opcode;
			lin.a  = a_in[i];
			lin.b  = b_in[i];
			lin.f  = f_in;
			if (i < 3) begin
				lin.ca = a_in[(i + 1) % 3];
				lin.cb = b_in[(i + 2) % 3];
				lin.cc = a_in[(i + 2) % 3];
				lin.cd = b_in[(i + 1) % 3];
			end else begin
				lin.ca = '0;
				lin.cb = '0;
				lin.cc = '0;
				lin.cd = '0;
			end
		end
		ivalu_lane u_lane (
			.clk      (clk),
			.en       (en),
			.lin      (lin),
			.res_s1   (lane_s1[i]),
			.cross_s2 (cross_s2[i])
		);
	end

	// Stage 1 context
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_d;
		end
	end

	// Stage 2: lane merge, dot product and sum of squares
	always_ff @(posedge clk) begin
		ivalu_pkg::ctx_t  c;
		ivalu_pkg::comp_t dot;
		ivalu_pkg::comp_t sq;
		if (en) begin
			c   = ctx_s1;
			dot = '0;
			sq  = '0;
			for (int i = 0; i < L; i++) begin
				if (3'(i) < ctx_s1.n) begin
					c.vec[i] = lane_s1[i].vec;
					dot      = dot + lane_s1[i].ab;
					sq       = sq + lane_s1[i].aa;
				end else begin
					c.vec[i] = '0;
				end
			end
			if (ctx_s1.op == ivalu_pkg::OP_DOT) c.sc = dot;
			ctx_s2   <= c;
			sqsum_s2 <= sq;
		end
	end

	// Cross product merge at the square root entry
	always_comb begin
		sq_in = ctx_s2;
		if (ctx_s2.op == ivalu_pkg::OP_CROSS) begin
			if (ctx_s2.n == 3'd2) begin
				sq_in.sc = cross_s2[2];
			end else if (ctx_s2.n == 3'd3) begin
				sq_in.vec = {ivalu_pkg::comp_t'('0), cross_s2[2], cross_s2[1], cross_s2[0]};
			end
		end
	end

	// A negative wrapped sum of squares has magnitude zero
	assign sqrt_val = sqsum_s2[W-1] ? '0 : W'(sqsum_s2);

	ivalu_sqrt u_sqrt (
		.clk   (clk),
		.en    (en),
		.value (sqrt_val),
		.root  (mag)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sq[0] <= sq_in;
			for (int k = 1; k < SQ; k++) ctx_sq[k] <= ctx_sq[k-1];
		end
	end

	// Magnitude merge and divisor selection at the divider entry
	always_comb begin
		dv_in = ctx_sq[SQ-1];
		if (dv_in.op == ivalu_pkg::OP_MAG) dv_in.sc = mag;
		if (dv_in.op == ivalu_pkg::OP_NORM && mag == '0) dv_in.st = ivalu_pkg::ST_DIV0;
		for (int i = 0; i < L; i++) begin
			case (dv_in.op)
				ivalu_pkg::OP_DIV:  dvsr[i] = dv_in.f;
				ivalu_pkg::OP_NORM: dvsr[i] = mag;
				default:            dvsr[i] = dv_in.b[i];
			endcase
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_div
		ivalu_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (dv_in.a[i]),
			.divisor  (dvsr[i]),
			.quot     (quot[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dv[0] <= dv_in;
			for (int k = 1; k < DV; k++) ctx_dv[k] <= ctx_dv[k-1];
		end
	end

	// Final merge: quotients, quotient sum, error zeroing
	always_comb begin
		ivalu_pkg::comp_t qs;
		fin = ctx_dv[DV-1];
		qs  = '0;
		for (int i = 0; i < L; i++) begin
			if (3'(i) < fin.n) begin
				qs = qs + quot[i];
				if (fin.op == ivalu_pkg::OP_DIV || fin.op == ivalu_pkg::OP_NORM) begin
					fin.vec[i] = quot[i];
				end
			end
		end
		if (fin.op == ivalu_pkg::OP_QSUM) fin.sc = qs;
		if (fin.st != ivalu_pkg::ST_OK) begin
			fin.vec = '0;
			fin.sc  = '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.r_x      <= 32'(fin.vec[0]);
			rsp_q.r_y      <= 32'(fin.vec[1]);
			rsp_q.r_z      <= 32'(fin.vec[2]);
			rsp_q.r_w      <= 32'(fin.vec[3]);
			rsp_q.r_scalar <= 32'(fin.sc);
			rsp_q.status   <= fin.st;
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_sq        <= '{default: 1'b0};
			v_dv        <= '{default: 1'b0};
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1  <= req_valid;
			v_s2  <= v_s1;
			v_sq[0] <= v_s2;
			for (int k = 1; k < SQ; k++) v_sq[k] <= v_sq[k-1];
			v_dv[0] <= v_sq[SQ-1];
			for (int k = 1; k < DV; k++) v_dv[k] <= v_dv[k-1];
			rsp_valid_q <= v_dv[DV-1];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// All result fields zero
	assign rsp_zero = (rsp.r_x == '0) && (rsp.r_y == '0) && (rsp.r_z == '0) &&
	                  (rsp.r_w == '0) && (rsp.r_scalar == '0);

	`IVALU_IMPLIES(a_stall_needs_result, req_stall, rsp_valid)
	`IVALU_IMPLIES(a_error_zeroes, rsp_valid && rsp.status != ivalu_pkg::ST_OK, rsp_zero)
	`IVALU_NEXT(a_held_result, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

`default_nettype wire

/* tb/tb_integer_vector_alu.sv */
// Self-checking testbench for the integer vector ALU: directed corner requests, then
// random requests with random idling on both sides, checked against a built-in predictor.
// Depends on ivalu_pkg and integer_vector_alu.
`timescale 1ns / 1ps
`default_nettype none

module tb_integer_vector_alu;
	import ivalu_pkg::*;

	localparam int NUM_RANDOM = 1730;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	// Expected-result store with the ALU prediction built in
	class alu_scoreboard;
		rsp_t pending_rsps[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		static function logic signed [31:0] quot(logic signed [31:0] n, logic signed [31:0] d);
			if (n == MOST_NEG && d == -32'sd1)
				return MOST_NEG;
			return n / d;
		endfunction

		static function logic signed [31:0] magnitude_of(logic signed [31:0] v[4], int n);
			logic signed [31:0] s;
			logic [31:0] r;
			s = 0;
			for (int i = 0; i < n; i++)
				s = s + v[i] * v[i];
			if (s < 0)
				return 0;
			// bitwise floor square root
			r = 0;
			for (int b = 15; b >= 0; b--) begin
				logic [63:0] t;
				t = r | (32'd1 << b);
				if (t * t <= 64'(unsigned'(s)))
					r = t[31:0];
			end
			return r;
		endfunction

		static function rsp_t compute(req_t q);
			rsp_t r;
			logic signed [31:0] a[4], b[4], v[4], sc, m;
			logic [1:0] st;
			int n;
			a = '{q.a_x, q.a_y, q.a_z, q.a_w};
			b = '{q.b_x, q.b_y, q.b_z, q.b_w};
			v = '{0, 0, 0, 0};
			sc = 0;
			st = ST_OK;
			n = q.dims < 2 ? 2 : (q.dims > 4 ? 4 : int'(q.dims));
			case (q.opcode)
				OP_ADD: for (int i = 0; i < n; i++) v[i] = a[i] + b[i];
				OP_SUB: for (int i = 0; i < n; i++) v[i] = a[i] - b[i];
				OP_SCALE: for (int i = 0; i < n; i++) v[i] = a[i] * q.factor;
				OP_DIV: begin
					if (q.factor == 0) st = ST_DIV0;
					else for (int i = 0; i < n; i++) v[i] = quot(a[i], q.factor);
				end
				OP_DOT: for (int i = 0; i < n; i++) sc = sc + a[i] * b[i];
				OP_CROSS: begin
					if (n == 2) begin
						sc = a[0] * b[1] - a[1] * b[0];
					end else if (n == 3) begin
						v[0] = a[1] * b[2] - a[2] * b[1];
						v[1] = a[2] * b[0] - a[0] * b[2];
						v[2] = a[0] * b[1] - a[1] * b[0];
					end else begin
						st = ST_CROSS4;
					end
				end
				OP_MAG: sc = magnitude_of(a, n);
				OP_NORM: begin
					m = magnitude_of(a, n);
					if (m == 0) st = ST_DIV0;
					else for (int i = 0; i < n; i++) v[i] = quot(a[i], m);
				end
				OP_QSUM: begin
					for (int i = 0; i < n; i++)
						if (b[i] == 0) st = ST_DIV0;
					if (st == ST_OK)
						for (int i = 0; i < n; i++) sc = sc + quot(a[i], b[i]);
				end
				default: ;
			endcase
			if (st != ST_OK) begin
				v = '{0, 0, 0, 0};
				sc = 0;
			end
			r.r_x = v[0];
			r.r_y = v[1];
			r.r_z = v[2];
			r.r_w = v[3];
			r.r_scalar = sc;
			r.status = st;
			return r;
		endfunction

		function void note_request(req_t q);
			pending_rsps.push_back(compute(q));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_rsps.pop_front();
			if (got.r_x !== want.r_x)
				$display("%0t: r_x expected %h actual %h", $time, want.r_x, got.r_x);
			if (got.r_y !== want.r_y)
				$display("%0t: r_y expected %h actual %h", $time, want.r_y, got.r_y);
			if (got.r_z !== want.r_z)
				$display("%0t: r_z expected %h actual %h", $time, want.r_z, got.r_z);
			if (got.r_w !== want.r_w)
				$display("%0t: r_w expected %h actual %h", $time, want.r_w, got.r_w);
			if (got.r_scalar !== want.r_scalar)
				$display("%0t: r_scalar expected %h actual %h", $time,
					want.r_scalar, got.r_scalar);
			if (got.status !== want.status)
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	alu_scoreboard sb = new();
	bit quiet_phase = 1'b0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	integer_vector_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Component value biased toward edges and small magnitudes
	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return 32'(-1);
			3: return 0;
			4, 5: return 32'($urandom_range(0, 200)) - 32'sd100;
			6: return 32'($urandom_range(0, 80000)) - 32'sd40000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rand_request();
		req_t q;
		q.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		q.dims = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
		q.a_x = rand_comp();
		q.a_y = rand_comp();
		q.a_z = rand_comp();
		q.a_w = rand_comp();
		q.b_x = rand_comp();
		q.b_y = rand_comp();
		q.b_z = rand_comp();
		q.b_w = rand_comp();
		q.factor = rand_comp();
		return q;
	endfunction

	// Send one request, optionally preceded by an idle burst
	task automatic send_request(req_t q);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(q);
	endtask

	task automatic send_directed();
		req_t q;
		logic [3:0] ops[$];
		ops = '{OP_ADD, OP_SUB, OP_SCALE, OP_DIV, OP_DOT, OP_CROSS, OP_MAG, OP_NORM, OP_QSUM};
		// every opcode with extreme operands at varying dimensions
		foreach (ops[i]) begin
			q = '{ops[i], 3'(2 + i % 3), MOST_NEG, MOST_POS, 32'(-1), MOST_NEG,
				32'(-1), MOST_NEG, MOST_POS, 32'(-1), 32'(-1)};
			send_request(q);
		end
		// divide by zero, zero magnitude, zero divisor in quotient sum
		send_request('{OP_DIV, 3'd3, 32'sd7, -32'sd9, 32'sd1, 32'sd5, 0, 0, 0, 0, 0});
		send_request('{OP_NORM, 3'd4, 0, 0, 0, 0, 1, 1, 1, 1, 0});
		send_request('{OP_QSUM, 3'd3, 5, 6, 7, 8, 1, 2, 0, 9, 0});
		// sum of squares that overflows and wraps
		send_request('{OP_MAG, 3'd2, 32'sd46341, 32'sd46341, 0, 0, 0, 0, 0, 0, 0});
		send_request('{OP_NORM, 3'd2, 32'sd46341, 32'sd46341, 0, 0, 0, 0, 0, 0, 0});
		// cross in 3D and 4D, dims out of range, unknown opcodes
		send_request('{OP_CROSS, 3'd3, 1, 2, 3, 4, 5, 6, 7, 8, 0});
		send_request('{OP_CROSS, 3'd4, 1, 2, 3, 4, 5, 6, 7, 8, 0});
		send_request('{OP_ADD, 3'd0, 1, 2, 3, 4, 5, 6, 7, 8, 0});
		send_request('{OP_DOT, 3'd1, 1, 2, 3, 4, 5, 6, 7, 8, 0});
		send_request('{OP_SUB, 3'd7, 1, 2, 3, 4, 5, 6, 7, 8, 0});
		send_request('{4'd15, 3'd4, 1, 2, 3, 4, 5, 6, 7, 8, 9});
		send_request('{4'd9, 3'd5, MOST_POS, 2, 3, 4, 5, 6, 7, 8, 9});
		send_request('{OP_NORM, 3'd3, 3, 4, 12, 0, 0, 0, 0, 0, 0});
	endtask

	// Receiver: random stall bursts, checks each accepted result
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp);
			if (!quiet_phase && rsp_stall == 1'b0 && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8) - 1) begin
					@(posedge clk);
					if (rsp_valid && !rsp_stall)
						sb.check_result(rsp);
				end
				@(posedge clk);
				if (rsp_valid && !rsp_stall)
					sb.check_result(rsp);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_integer_vector_alu: errors");
			$finish;
		end
	end

	// Sender, drain and final verdict
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2) begin
				// hold off until the pipeline has drained
				req_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending_rsps.size() != 0) @(posedge clk);
			end
			if (i == NUM_RANDOM - 300)
				quiet_phase = 1'b1;
			send_request(rand_request());
		end
		req_valid <= 1'b0;
		while (sb.pending_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_integer_vector_alu: clean");
		else
			$display("tb_integer_vector_alu: errors");
		$finish;
	end

endmodule

`default_nettype wire

/* integer_vector_alu.f */
+incdir+hdl
hdl/ivalu_pkg.sv
hdl/ivalu_lane.sv
hdl/ivalu_sqrt.sv
hdl/ivalu_div.sv
hdl/integer_vector_alu.sv
tb/tb_integer_vector_alu.sv
